/* hdl/tasq_pkg.sv */
// Package for the text-to-allophone speech queue.
// Holds the transfer payload types, command codes, the letter table and the byte mapper.
// No dependencies.
package tasq_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_AW = 1;

    localparam logic [7:0] ASCII_A = 8'h61;
    localparam logic [7:0] ASCII_Z = 8'h7A;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] HIGH_BYTE = 8'h80;
    localparam logic [7:0] STATUS_IDLE = 8'hFF;
    localparam int STATUS_PENDING_BIT = 7;
    localparam int STATUS_SPEAKING_BIT = 6;

    localparam logic [5:0] ALLO_PAUSE = 6'h02;

    localparam logic [5:0] LETTER_CODE [26] = '{
        6'h14, 6'h1C, 6'h37, 6'h15, 6'h13, 6'h28, 6'h24, 6'h1B, 6'h06, 6'h0A,
        6'h2A, 6'h2D, 6'h10, 6'h0B, 6'h35, 6'h09, 6'h29, 6'h0E, 6'h37, 6'h11,
        6'h16, 6'h23, 6'h2E, 6'h37, 6'h31, 6'h2B
    };

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_STATUS = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       speech_busy;
    } t_in_item;

    typedef struct packed {
        logic [7:0] status;
        logic       write_taken;
        logic       allophone_valid;
        logic [5:0] allophone;
    } t_out_item;

    typedef struct packed {
        logic       is_tick;
        logic       speech_busy;
        logic       push;
        logic [5:0] code;
        logic       write_taken;
        logic       pending;
    } t_op;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } t_map;

    function automatic t_map map_byte(input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] idx;
        t_map       m;
        c = b | CASE_BIT;
        idx = c - ASCII_A;
        m.hit = 1'b0;
        m.code = '0;
        if (c >= ASCII_A && c <= ASCII_Z) begin
            m.hit = 1'b1;
            m.code = LETTER_CODE[idx[4:0]];
        end else if (c == ASCII_SPACE) begin
            m.hit = 1'b1;
            m.code = ALLO_PAUSE;
        end
        return m;
    endfunction

endpackage

/* hdl/tasq_front.sv */
// Front end of the text-to-allophone speech queue.
// Latches command bytes, classifies each transfer and maps pending bytes to allophones.
// Depends on tasq_pkg.
module tasq_front
    import tasq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_op_ready,
    output logic     o_op_valid,
    output t_op      o_op
);

    logic       r_pending;
    logic [7:0] r_byte;
    logic       n_pending;
    logic [7:0] n_byte;
    logic       w_accept;
    t_map       w_map;

    assign w_accept = i_in_valid && i_op_ready;
    assign o_op_valid = i_in_valid;
    assign w_map = map_byte(r_byte);

    always_comb begin
        n_pending = r_pending;
        n_byte = r_byte;
        o_op = '0;
        o_op.speech_busy = i_in_item.speech_busy;
        unique case (i_in_item.cmd)
            CMD_WRITE: begin
                if (!r_pending) begin
                    n_pending = 1'b1;
                    n_byte = i_in_item.data;
                    o_op.write_taken = 1'b1;
                end
            end
            CMD_TICK: begin
                o_op.is_tick = 1'b1;
                if (r_pending) begin
                    o_op.push = (r_byte < HIGH_BYTE) && w_map.hit;
                    o_op.code = w_map.code;
                end
                n_pending = 1'b0;
            end
            CMD_STATUS, CMD_NONE: begin
            end
            default: begin
            end
        endcase
        o_op.pending = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_byte <= '0;
        end else if (w_accept) begin
            r_pending <= n_pending;
            r_byte <= n_byte;
        end
    end

endmodule

/* hdl/tasq_op_queue.sv */
// Short queue of classified operations between the front and back ends.
// Two register entries with valid and ready on both sides.
// Depends on tasq_pkg.
module tasq_op_queue
    import tasq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_op  i_wr_op,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_op  o_rd_op
);

    localparam int CW = $clog2(OPQ_DEPTH + 1);

    t_op               r_entry [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wr_ptr;
    logic [OPQ_AW-1:0] r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_wr_ready = (r_count != CW'(OPQ_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_op = r_entry[r_rd_ptr];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(w_wr) - CW'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= i_wr_op;
        end
    end

endmodule

/* hdl/tasq_back.sv */
// Back end of the text-to-allophone speech queue.
// Holds the allophone FIFO memory, issues codes to the speech chip and builds each result.
// Depends on tasq_pkg.
module tasq_back
    import tasq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_op_valid,
    output logic      o_op_ready,
    input  t_op       i_op,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [5:0]    r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_fill;
    logic          r_busy_seen;
    logic          r_out_valid;
    logic [7:0]    r_status;
    logic          r_taken;
    logic          r_allo_valid;
    logic          r_bypass;
    logic [5:0]    r_byp_code;
    logic [5:0]    r_rd_data;

    logic [AW-1:0] n_wp;
    logic [AW-1:0] n_rp;
    logic [CW-1:0] n_fill;
    logic          n_busy_seen;
    logic [7:0]    n_status;
    logic [CW-1:0] w_fill_mid;
    logic          w_push;
    logic          w_pop;
    logic          w_adv;

    assign o_op_ready = !r_out_valid || i_out_ready;
    assign w_adv = i_op_valid && o_op_ready;

    always_comb begin
        w_push = i_op.is_tick && i_op.push && (r_fill != CW'(QUEUE_DEPTH));
        w_fill_mid = r_fill + CW'(w_push);
        w_pop = i_op.is_tick && !i_op.speech_busy && (w_fill_mid != '0);
        n_fill = w_fill_mid - CW'(w_pop);
        n_wp = r_wp;
        n_rp = r_rp;
        if (w_push) begin
            n_wp = (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        n_busy_seen = i_op.is_tick ? (i_op.speech_busy || w_pop) : r_busy_seen;
        n_status = STATUS_IDLE;
        n_status[STATUS_PENDING_BIT] = !i_op.pending;
        n_status[STATUS_SPEAKING_BIT] = !(n_busy_seen || (n_fill != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_fill <= '0;
            r_busy_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_wp <= n_wp;
                r_rp <= n_rp;
                r_fill <= n_fill;
                r_busy_seen <= n_busy_seen;
            end
            if (o_op_ready) begin
                r_out_valid <= i_op_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status <= n_status;
            r_taken <= i_op.write_taken;
            r_allo_valid <= w_pop;
            r_bypass <= (r_fill == '0);
            r_byp_code <= i_op.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_push) begin
            r_mem[r_wp] <= i_op.code;
        end
        if (w_adv && w_pop) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result.status = r_status;
    assign o_result.write_taken = r_taken;
    assign o_result.allophone_valid = r_allo_valid;
    assign o_result.allophone = !r_allo_valid ? 6'd0 : (r_bypass ? r_byp_code : r_rd_data);

endmodule

/* hdl/text_to_allophone_speech_queue.sv */
// Speech-controller register interface with a text-to-allophone queue (top level).
// Depends on tasq_pkg, tasq_front, tasq_op_queue and tasq_back.
//
// Every transfer in (a command write, a status read or a tick) yields exactly one result
// transfer out, in order. The block takes one transfer per cycle for as long as the output
// side keeps up; each transfer is registered in the operation queue and its result is then
// registered in the back end before it is offered. Command bytes are
// latched and mapped in the front end, and the allophone FIFO of QUEUE_DEPTH entries lives
// in a single memory in the back end with one write and one registered read per cycle.
// The FIFO memory is not cleared after reset; only entries already written are ever issued.
module text_to_allophone_speech_queue
    import tasq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_result
);

    logic w_fe_valid;
    logic w_fe_ready;
    t_op  w_fe_op;
    logic w_be_valid;
    logic w_be_ready;
    t_op  w_be_op;

    assign o_in_ready = w_fe_ready;

    tasq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_op_ready (w_fe_ready),
        .o_op_valid (w_fe_valid),
        .o_op       (w_fe_op)
    );

    tasq_op_queue u_op_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fe_valid),
        .o_wr_ready (w_fe_ready),
        .i_wr_op    (w_fe_op),
        .o_rd_valid (w_be_valid),
        .i_rd_ready (w_be_ready),
        .o_rd_op    (w_be_op)
    );

    tasq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_be_valid),
        .o_op_ready  (w_be_ready),
        .i_op        (w_be_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

/* hdl/tasq_checker.sv */
// Port-level checker for the text-to-allophone speech queue, bound to the top level.
// Depends on tasq_pkg and text_to_allophone_speech_queue.
module tasq_checker
    import tasq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result))
        else $error("Stalled result transfer changed.");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result.allophone_valid |-> o_result.allophone == 6'd0)
        else $error("Allophone code is nonzero without an issue.");

    a_issue_speaking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.allophone_valid |-> !o_result.status[STATUS_SPEAKING_BIT])
        else $error("Issued allophone without the speaking status.");

    a_taken_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.write_taken |-> !o_result.status[STATUS_PENDING_BIT])
        else $error("Latched write without the pending status.");

    a_status_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result.status[5:0] == STATUS_IDLE[5:0])
        else $error("Unused status bits are not set.");

endmodule

bind text_to_allophone_speech_queue tasq_checker u_tasq_checker (.*);

/* tb/text_to_allophone_speech_queue_test.sv */
// Self-checking testbench for the text-to-allophone speech queue.
// A scoreboard class tracks the command latch, the allophone FIFO and the status bits,
// and checks every result transfer in order. Depends on tasq_pkg and the top level RTL.
`timescale 1ns / 1ps

module text_to_allophone_speech_queue_test;
    import tasq_pkg::*;

    localparam int FIFO_CAPACITY = QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic [5:0] PAUSE_CODE = 6'h02;
    localparam logic [5:0] SPEECH_CODES [26] = '{
        6'h14, 6'h1C, 6'h37, 6'h15, 6'h13, 6'h28, 6'h24, 6'h1B, 6'h06, 6'h0A,
        6'h2A, 6'h2D, 6'h10, 6'h0B, 6'h35, 6'h09, 6'h29, 6'h0E, 6'h37, 6'h11,
        6'h16, 6'h23, 6'h2E, 6'h37, 6'h31, 6'h2B
    };

    class speech_scoreboard;
        logic        cmd_pending;
        logic [7:0]  cmd_byte;
        logic        speaker_busy;
        logic [5:0]  allophone_fifo [$];
        t_out_item   results_due [$];
        int unsigned mismatches;

        function new();
            cmd_pending = 1'b0;
            cmd_byte = 8'h00;
            speaker_busy = 1'b0;
            mismatches = 0;
        endfunction

        function void note_accepted_item(input t_in_item it);
            t_out_item  r;
            logic [7:0] lc;
            r = '0;
            case (it.cmd)
                CMD_WRITE: begin
                    if (!cmd_pending) begin
                        cmd_byte = it.data;
                        cmd_pending = 1'b1;
                        r.write_taken = 1'b1;
                    end
                end
                CMD_TICK: begin
                    speaker_busy = it.speech_busy;
                    if (cmd_pending && cmd_byte < 8'h80) begin
                        lc = cmd_byte | 8'h20;
                        if (allophone_fifo.size() < FIFO_CAPACITY) begin
                            if (lc >= 8'h61 && lc <= 8'h7A) begin
                                allophone_fifo.push_back(SPEECH_CODES[lc - 8'h61]);
                            end else if (lc == 8'h20) begin
                                allophone_fifo.push_back(PAUSE_CODE);
                            end
                        end
                    end
                    cmd_pending = 1'b0;
                    if (!it.speech_busy && allophone_fifo.size() != 0) begin
                        r.allophone = allophone_fifo.pop_front();
                        r.allophone_valid = 1'b1;
                        speaker_busy = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.status = 8'hFF;
            if (cmd_pending) begin
                r.status[7] = 1'b0;
            end
            if (speaker_busy || allophone_fifo.size() != 0) begin
                r.status[6] = 1'b0;
            end
            results_due.push_back(r);
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing expected, got %p", $time, got);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %h, got %h",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.write_taken !== want.write_taken) begin
                $display("%0t: write_taken mismatch, expected %b, got %b",
                         $time, want.write_taken, got.write_taken);
                mismatches++;
            end
            if (got.allophone_valid !== want.allophone_valid) begin
                $display("%0t: allophone_valid mismatch, expected %b, got %b",
                         $time, want.allophone_valid, got.allophone_valid);
                mismatches++;
            end
            if (got.allophone !== want.allophone) begin
                $display("%0t: allophone mismatch, expected %h, got %h",
                         $time, want.allophone, got.allophone);
                mismatches++;
            end
        endfunction

        function int unsigned results_waiting();
            return results_due.size();
        endfunction

        function int unsigned codes_queued();
            return allophone_fifo.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_result;

    speech_scoreboard sb;
    bit               sender_gaps;
    bit               receiver_stalls;
    int unsigned      items_sent;
    int unsigned      idle_cycles = 0;

    text_to_allophone_speech_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_accepted_item(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL text_to_allophone_speech_queue");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (receiver_stalls && $urandom_range(0, 99) < 20) begin
                    if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(10, 40);
                    end else begin
                        stall_left = $urandom_range(1, 3);
                    end
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer, once any random sender gap is over.
    task automatic send_item(input t_cmd cmd, input logic [7:0] data, input logic busy);
        t_in_item it;
        int       pick;
        it.cmd = cmd;
        it.data = data;
        it.speech_busy = busy;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        @(negedge i_clk);
        if (sender_gaps) begin
            pick = $urandom_range(0, 99);
            if (pick >= 65) begin
                i_in_valid <= 1'b0;
                if (pick < 93) begin
                    repeat ($urandom_range(1, 3)) @(negedge i_clk);
                end else begin
                    repeat ($urandom_range(8, 30)) @(negedge i_clk);
                end
            end
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.results_waiting() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return 8'h20;
        end else if (pick == 1) begin
            return 8'h00;
        end else if (pick < 10) begin
            return 8'h41 + 8'($urandom_range(0, 25));
        end
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic random_busy();
        return ($urandom_range(0, 9) < 3);
    endfunction

    initial begin
        int         pick;
        logic [7:0] b;
        sb = new();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        items_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(CMD_STATUS, 8'hFF, 1'b1);
        send_item(CMD_NONE, 8'hA5, 1'b0);
        send_item(CMD_WRITE, 8'h41, 1'b0);
        send_item(CMD_WRITE, 8'h7A, 1'b1);
        send_item(CMD_STATUS, 8'h00, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b1);
        send_item(CMD_TICK, 8'hFF, 1'b0);
        send_item(CMD_WRITE, 8'h00, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'h80, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'hFF, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'h31, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b1);
        send_item(CMD_WRITE, 8'h5A, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'h60, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'h7F, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'h40, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_NONE, 8'h5A, 1'b1);
        wait_for_results();

        // Send more write-and-tick pairs than the FIFO holds while the speech chip stays busy, then drain it.
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        repeat (FIFO_CAPACITY + 6) begin
            send_item(CMD_WRITE, random_text_byte(), random_busy());
            send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
        end
        send_item(CMD_STATUS, 8'($urandom_range(0, 255)), 1'b0);
        while (sb.codes_queued() != 0) begin
            send_item(CMD_TICK, 8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
        end
        send_item(CMD_TICK, 8'h00, 1'b0);
        wait_for_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            sender_gaps = ((items_sent / 100) % 4 != 3);
            receiver_stalls = ((items_sent / 100) % 4 != 3);
            if (items_sent >= RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 4) begin
                wait_for_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_item(CMD_WRITE, random_text_byte(), random_busy());
                if ($urandom_range(0, 4) == 0) begin
                    send_item(CMD_STATUS, 8'($urandom_range(0, 255)), random_busy());
                end
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), random_busy());
            end else if (pick < 67) begin
                b = 8'($urandom_range(0, 255));
                send_item(CMD_WRITE, b, random_busy());
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), random_busy());
            end else if (pick < 77) begin
                send_item(CMD_WRITE, random_text_byte(), random_busy());
                send_item(CMD_WRITE, 8'($urandom_range(0, 255)), random_busy());
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), random_busy());
            end else if (pick < 89) begin
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), random_busy());
            end else if (pick < 95) begin
                send_item(CMD_STATUS, 8'($urandom_range(0, 255)), random_busy());
            end else begin
                send_item(CMD_NONE, 8'($urandom_range(0, 255)), random_busy());
            end
        end

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.results_waiting() == 0) begin
            $display("PASS text_to_allophone_speech_queue");
        end else begin
            $display("FAIL text_to_allophone_speech_queue");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/tasq_pkg.sv
hdl/tasq_front.sv
hdl/tasq_op_queue.sv
hdl/tasq_back.sv
hdl/text_to_allophone_speech_queue.sv
hdl/tasq_checker.sv
tb/text_to_allophone_speech_queue_test.sv
